>>> hw/rtl/aes_pkg.sv
// aes_pkg: shared types, constants and byte functions for the aes block cipher
// no dependencies; used by aes_key_sched and aes_block_cipher
package aes_pkg;

	localparam int unsigned MaxRoundsDefault = 14;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_KEY_SIZE  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_WORD0 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_WORD1 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_WORD2 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KEY_WORD3 = 3'd4;

	localparam logic KIND_ENCRYPT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} ks_ctrl_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = xtime(x);
		end
		gmul = acc;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

>>> hw/rtl/aes_key_sched.sv
// aes_key_sched: round-key expansion, one word a cycle, into a key memory
// depends on aes_pkg; instantiated by aes_block_cipher
module aes_key_sched #(
	parameter int unsigned MAX_ROUNDS = aes_pkg::MaxRoundsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aes_pkg::ks_ctrl_t    ctrl,
	input  logic [1:0]           key_size,
	input  logic [255:0]         key,
	output logic                 done,
	output logic [3:0]           num_rounds,
	input  logic [$clog2(MAX_ROUNDS+1)-1:0] rd_round,
	output logic [127:0]         rd_key
);
	localparam int unsigned Words = 4 * (MAX_ROUNDS + 1);
	localparam int unsigned WIdxW = $clog2(Words + 1);
	localparam int unsigned RowW  = $clog2(MAX_ROUNDS + 1);

	// memory holds one round key (four words) per row; history of last eight words in flops
	logic [127:0] mem [MAX_ROUNDS+1];
	logic [31:0]  win_q [8];
	logic [WIdxW-1:0] idx_q;
	logic [WIdxW-1:0] total;
	logic [3:0]   nk;
	logic [2:0]   pos_q;
	logic [7:0]   rc_q;
	logic         run_q;
	logic [31:0]  prev, back, t, nw;
	logic [127:0] row_q;

	function automatic logic [31:0] sub_word_rot(input logic [31:0] w);
		sub_word_rot = aes_pkg::sub_word({w[23:0], w[31:24]});
	endfunction

	always_comb begin
		unique case (key_size)
			2'd0: begin nk = 4'd4; num_rounds = 4'd10; end
			2'd1: begin nk = 4'd6; num_rounds = 4'd12; end
			default: begin nk = 4'd8; num_rounds = 4'd14; end
		endcase
		total = WIdxW'(4 * (32'(num_rounds) + 1));
	end

	always_comb begin
		prev = win_q[0];
		back = win_q[3'(nk - 4'd1)];
		if (pos_q == 3'd0) begin
			t = sub_word_rot(prev) ^ {rc_q, 24'h0};
		end else if (nk == 4'd8 && pos_q == 3'd4) begin
			t = aes_pkg::sub_word(prev);
		end else begin
			t = prev;
		end
		nw = back ^ t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
			done  <= 1'b0;
		end else if (ctrl.start) begin
			run_q <= 1'b1;
			idx_q <= '0;
			done  <= 1'b0;
		end else if (run_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q + 1'b1 == total) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end else if (ctrl.busy) begin
			done <= done;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] w;
		if (ctrl.start) begin
			pos_q <= 3'd0;
			rc_q  <= 8'h01;
		end else if (run_q) begin
			if (idx_q < WIdxW'(nk)) begin
				w = key[255 - 32*int'(idx_q[2:0]) -: 32];
			end else begin
				w = nw;
				if (pos_q == 3'd0) rc_q <= aes_pkg::xtime(rc_q);
				pos_q <= (pos_q + 3'd1 == 3'(nk)) ? 3'd0 : pos_q + 3'd1;
			end
			for (int i = 7; i > 0; i--) win_q[i] <= win_q[i-1];
			win_q[0] <= w;
			row_q <= {row_q[95:0], w};
			if (idx_q[1:0] == 2'd3) mem[RowW'(idx_q >> 2)] <= {row_q[95:0], w};
		end
		rd_key <= mem[rd_round];
	end
endmodule

>>> hw/rtl/aes_block_cipher.sv
// aes_block_cipher: iterative aes-128/192/256 encrypt and decrypt, one round a cycle
// depends on aes_pkg and aes_key_sched
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tuser: kind; tdata: block_high[63:0], block_low[127:64]
// m_axis   out  tvalid/tready    tdata: result_high[63:0], result_low[127:64]
// cfg      in   valid/ready      index[2:0], data[63:0]
//
// an accepted item gets the whitening and then every round in the one shared round
// unit before its result is offered; the first item after reset or after a write to the key
// size or a key word waits first for the key expansion.
// reset clears control and key registers only; key memory is always rewritten before read
// s_axis_tready is low from acceptance until the result has been taken; cfg_ready only idle
module aes_block_cipher #(
	parameter int unsigned MAX_ROUNDS = aes_pkg::MaxRoundsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // block_high, block_low
	input  logic         s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // result_high, result_low
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [aes_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [aes_pkg::CfgDataW-1:0] cfg_data
);
	localparam int unsigned RowW = $clog2(MAX_ROUNDS + 1);

	aes_pkg::ctrl_state_t state_q, state_d;
	aes_pkg::ks_ctrl_t    ks_ctrl;
	logic [1:0]   key_size_q;
	logic [255:0] key_q;
	logic         sched_ok_q;
	logic         kind_q;
	logic [127:0] st_q;
	logic [RowW-1:0] rnd_q;
	logic [3:0]   nr;
	logic         ks_done;
	logic [127:0] rk;
	logic         first_q;
	logic         out_v_q;
	logic [127:0] round_out;
	logic [RowW-1:0] rd_round;
	logic         at_last;

	assign cfg_ready = (state_q == aes_pkg::ST_IDLE);
	assign at_last = (kind_q == aes_pkg::KIND_ENCRYPT) ? (rnd_q == RowW'(nr)) : (rnd_q == '0);

	aes_key_sched #(.MAX_ROUNDS(MAX_ROUNDS)) u_ks (
		.clk, .arst_n, .ctrl(ks_ctrl), .key_size(key_size_q), .key(key_q),
		.done(ks_done), .num_rounds(nr), .rd_round(rd_round), .rd_key(rk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= 2'd0;
			key_q      <= '0;
			sched_ok_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					aes_pkg::REG_KEY_SIZE: begin
						key_size_q <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
						sched_ok_q <= 1'b0;
					end
					aes_pkg::REG_KEY_WORD0: begin key_q[255:192] <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KEY_WORD1: begin key_q[191:128] <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KEY_WORD2: begin key_q[127:64]  <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KEY_WORD3: begin key_q[63:0]    <= cfg_data; sched_ok_q <= 1'b0; end
					default: ;
				endcase
			end else if (state_q == aes_pkg::ST_EXPAND && ks_done && !ks_ctrl.start) begin
				sched_ok_q <= 1'b1;
			end
		end
	end

	// round counter counts up for encrypt and down for decrypt; key row is addressed the cycle before use
	always_comb begin
		if (state_q == aes_pkg::ST_ROUND && first_q)
			rd_round = (kind_q == aes_pkg::KIND_ENCRYPT) ? RowW'(1) : RowW'(nr) - 1'b1;
		else if (state_q == aes_pkg::ST_ROUND && !at_last)
			rd_round = (kind_q == aes_pkg::KIND_ENCRYPT) ? rnd_q + 1'b1 : rnd_q - 1'b1;
		else
			rd_round = (kind_q == aes_pkg::KIND_ENCRYPT) ? '0 : RowW'(nr);
	end

	// shared round unit
	always_comb begin
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic       last;
		for (int i = 0; i < 16; i++) s[i] = st_q[127 - 8*i -: 8];
		last = (kind_q == aes_pkg::KIND_ENCRYPT) ? (rnd_q == RowW'(nr)) : (rnd_q == '0);
		if (kind_q == aes_pkg::KIND_ENCRYPT) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					t[r + 4*c] = aes_pkg::SBOX[s[r + 4*((c + r) % 4)]];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					m[4*c + r] = last ? t[4*c + r] :
						aes_pkg::xtime(t[4*c + r]) ^ aes_pkg::xtime(t[4*c + (r+1)%4]) ^
						t[4*c + (r+1)%4] ^ t[4*c + (r+2)%4] ^ t[4*c + (r+3)%4];
			for (int i = 0; i < 16; i++) round_out[127 - 8*i -: 8] = m[i] ^ rk[127 - 8*i -: 8];
		end else begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					t[r + 4*((c + r) % 4)] = aes_pkg::ISBOX[s[r + 4*c]] ^
						rk[127 - 8*(r + 4*((c + r) % 4)) -: 8];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					m[4*c + r] = last ? t[4*c + r] :
						aes_pkg::gmul(8'h0e, t[4*c + r]) ^ aes_pkg::gmul(8'h0b, t[4*c + (r+1)%4]) ^
						aes_pkg::gmul(8'h0d, t[4*c + (r+2)%4]) ^ aes_pkg::gmul(8'h09, t[4*c + (r+3)%4]);
			for (int i = 0; i < 16; i++) round_out[127 - 8*i -: 8] = m[i];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aes_pkg::ST_IDLE:
				if (s_axis_tvalid && s_axis_tready) state_d = aes_pkg::ST_EXPAND;
			aes_pkg::ST_EXPAND:
				if (sched_ok_q || (ks_done && !ks_ctrl.start)) state_d = aes_pkg::ST_ROUND;
			aes_pkg::ST_ROUND: begin
				if (!first_q && at_last)
					state_d = aes_pkg::ST_DONE;
			end
			aes_pkg::ST_DONE:
				if (m_axis_tready) state_d = aes_pkg::ST_IDLE;
			default: state_d = aes_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == aes_pkg::ST_IDLE) && !cfg_valid;
		ks_ctrl.start = s_axis_tready && s_axis_tvalid && !sched_ok_q;
		ks_ctrl.busy  = (state_q == aes_pkg::ST_EXPAND);
		m_axis_tvalid = out_v_q;
		m_axis_tdata  = {st_q[63:0], st_q[127:64]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			first_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= (state_q == aes_pkg::ST_EXPAND);
			out_v_q <= (state_d == aes_pkg::ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_q <= s_axis_tuser;
			st_q   <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
		end else if (state_q == aes_pkg::ST_ROUND) begin
			if (first_q) begin
				// initial whitening with row 0 or row nr
				st_q  <= st_q ^ rk;
				rnd_q <= (kind_q == aes_pkg::KIND_ENCRYPT) ? RowW'(1) : RowW'(nr) - 1'b1;
			end else begin
				st_q  <= round_out;
				rnd_q <= (kind_q == aes_pkg::KIND_ENCRYPT) ? rnd_q + 1'b1 : rnd_q - 1'b1;
			end
		end
	end
endmodule

>>> bench/aes_block_cipher_tb.sv
// aes_block_cipher_tb: self-checking bench for the aes block cipher, ecb encrypt and decrypt
// depends on aes_pkg (register indexes, direction code) and the aes_block_cipher rtl
module aes_block_cipher_tb;

	typedef logic [aes_pkg::CfgIdxW-1:0] cfg_idx_t;

	localparam logic KIND_DECRYPT = ~aes_pkg::KIND_ENCRYPT;
	localparam cfg_idx_t REG_SPARE_LO = aes_pkg::REG_KEY_WORD3 + 1'b1;
	localparam cfg_idx_t REG_SPARE_HI = '1;
	localparam int STALL_LIMIT = 5000;
	localparam int KEY_WORDS = 4 * (aes_pkg::MaxRoundsDefault + 1);
	localparam logic [7:0] AFFINE_C = 8'h63;
	localparam logic [7:0] POLY_LOW = 8'h1b;

	typedef logic [7:0] blk_t [16];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;  // block_high, block_low
	logic s_axis_tuser = 1'b0;  // kind
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;  // result_high, result_low
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = '0;
	logic [aes_pkg::CfgDataW-1:0] cfg_data = '0;

	aes_block_cipher dut (.*);

	always #1 clk = ~clk;

	// own copy of the key registers and the expanded schedule
	logic [1:0] key_size_reg;
	logic [63:0] key_word_reg [4];
	logic [31:0] sched [KEY_WORDS];
	logic sched_valid;
	int unsigned sched_rounds;
	logic [7:0] fwd_sbox [256];
	logic [7:0] inv_sbox [256];

	logic [127:0] result_queue [$];
	logic [127:0] last_result;
	bit no_gaps = 1'b0;
	int errors = 0;
	int n_blocks = 0, n_decrypts = 0, n_results = 0, n_writes = 0;
	int idle_cycles = 0;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
	endfunction

	function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = xt(a);
		end
		return acc;
	endfunction

	function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// inverse by a^254, then the affine map
	function automatic logic [7:0] sbox_entry(input logic [7:0] v);
		logic [7:0] b;
		b = 8'h01;
		for (int i = 7; i >= 0; i--) begin
			b = gf_product(b, b);
			if ((254 >> i) & 1) b = gf_product(b, v);
		end
		return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ AFFINE_C;
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
	endfunction

	function automatic void expand_key();
		int unsigned ks, nk, total;
		logic [7:0] rc;
		logic [31:0] t;
		ks = (key_size_reg > 2) ? 2 : key_size_reg;
		nk = 4 + 2 * ks;
		rc = 8'h01;
		sched_rounds = nk + 6;
		total = 4 * (sched_rounds + 1);
		for (int i = 0; i < nk; i++)
			sched[i] = (i & 1) ? key_word_reg[i >> 1][31:0] : key_word_reg[i >> 1][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = xt(rc);
			end else if (nk > 6 && i % nk == 4) begin
				t = subst_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
		sched_valid = 1'b1;
	endfunction

	function automatic blk_t add_key(input blk_t s, input int r);
		for (int c = 0; c < 4; c++)
			for (int b = 0; b < 4; b++)
				s[4 * c + b] ^= sched[4 * r + c][31 - 8 * b -: 8];
		return s;
	endfunction

	function automatic blk_t shift_sub(input blk_t s, input bit inverse);
		blk_t t;
		t = s;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (!inverse) s[r + 4 * c] = fwd_sbox[t[r + 4 * ((c + r) & 3)]];
				else s[r + 4 * ((c + r) & 3)] = inv_sbox[t[r + 4 * c]];
		return s;
	endfunction

	function automatic blk_t mix(input blk_t s, input bit inverse);
		logic [7:0] m [4];
		logic [7:0] t [4];
		if (!inverse) m = '{8'h02, 8'h03, 8'h01, 8'h01};
		else m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) t[r] = s[4 * c + r];
			for (int r = 0; r < 4; r++)
				s[4 * c + r] = gf_product(m[(4 - r) & 3], t[0]) ^ gf_product(m[(5 - r) & 3], t[1])
					^ gf_product(m[(6 - r) & 3], t[2]) ^ gf_product(m[(7 - r) & 3], t[3]);
		end
		return s;
	endfunction

	// returns {result_high, result_low}
	function automatic logic [127:0] cipher_block(input logic kind, input logic [127:0] blk);
		blk_t s;
		int nr;
		logic [127:0] res;
		if (!sched_valid) expand_key();
		nr = sched_rounds;
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
		if (kind == aes_pkg::KIND_ENCRYPT) begin
			s = add_key(s, 0);
			for (int r = 1; r < nr; r++) s = add_key(mix(shift_sub(s, 0), 0), r);
			s = add_key(shift_sub(s, 0), nr);
		end else begin
			s = add_key(s, nr);
			for (int r = nr - 1; r >= 1; r--) s = mix(add_key(shift_sub(s, 1), r), 1);
			s = add_key(shift_sub(s, 1), 0);
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
	endtask

	task automatic gap();
		while (!no_gaps && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo);
		gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {lo, hi};
		do @(posedge clk); while (!s_axis_tready);
		result_queue.push_back(cipher_block(kind, {hi, lo}));
		n_blocks++;
		if (kind != aes_pkg::KIND_ENCRYPT) n_decrypts++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (result_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
		while (!no_gaps && $urandom_range(99) < 35) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == aes_pkg::REG_KEY_SIZE) begin
			key_size_reg = value[1:0];
			sched_valid = 1'b0;
		end else if (idx >= aes_pkg::REG_KEY_WORD0 && idx <= aes_pkg::REG_KEY_WORD3) begin
			key_word_reg[2'(idx - aes_pkg::REG_KEY_WORD0)] = value;
			sched_valid = 1'b0;
		end
		n_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [1:0] size, input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3);
		write_reg(aes_pkg::REG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | size);
		write_reg(aes_pkg::REG_KEY_WORD0, w0);
		write_reg(aes_pkg::REG_KEY_WORD1, w1);
		write_reg(aes_pkg::REG_KEY_WORD2, w2);
		write_reg(aes_pkg::REG_KEY_WORD3, w3);
	endtask

	// blocks before any key write use the all-zero 128-bit key
	task automatic test_default_key();
		send_block(aes_pkg::KIND_ENCRYPT, '0, '0);
		send_block(aes_pkg::KIND_ENCRYPT, '1, '1);
		send_block(KIND_DECRYPT, '0, '0);
		send_block(KIND_DECRYPT, '1, '1);
		drain();
	endtask

	task automatic test_standard_keys();
		for (int ks = 0; ks < 4; ks++) begin
			load_key(2'(ks), 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
				64'h1011121314151617, 64'h18191a1b1c1d1e1f);
			send_block(aes_pkg::KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
			drain();
			send_block(KIND_DECRYPT, last_result[127:64], last_result[63:0]);
			send_block(KIND_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);
			drain();
		end
	endtask

	// writes to unused indexes must leave the schedule alone
	task automatic test_spare_index();
		load_key(2'd1, '1, '1, '1, '0);
		send_block(aes_pkg::KIND_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
		drain();
		for (int idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++) write_reg(cfg_idx_t'(idx), '1);
		send_block(aes_pkg::KIND_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block(KIND_DECRYPT, '1, '0);
		drain();
	endtask

	task automatic test_random_blocks(input int count);
		int per_key;
		logic [1:0] ks;
		per_key = count / 12;
		for (int k = 0; k < 12; k++) begin
			ks = (k < 4) ? k[1:0] : 2'($urandom_range(3));
			no_gaps = (k == 5);
			load_key(ks, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			for (int i = 0; i < per_key; i++) begin
				// some round trips: feed the last result back in, with a random kind
				if ($urandom_range(3) == 0 && result_queue.size() == 0)
					send_block(1'($urandom_range(1)), last_result[127:64], last_result[63:0]);
				else
					send_block(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
			end
			drain();
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		logic [127:0] want;
		logic [127:0] got;
		m_axis_tready <= no_gaps || ($urandom_range(99) >= 35);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled with %0d results outstanding", result_queue.size());
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			// tdata carries result_high in the low half
			got = {m_axis_tdata[63:0], m_axis_tdata[127:64]};
			last_result = got;
			if (result_queue.size() == 0) begin
				report("unexpected result_high", got[127:64], 64'h0);
			end else begin
				want = result_queue.pop_front();
				if (got[127:64] !== want[127:64])
					report("result_high", got[127:64], want[127:64]);
				if (got[63:0] !== want[63:0])
					report("result_low", got[63:0], want[63:0]);
			end
		end
	end

	initial begin
		for (int i = 0; i < 256; i++) fwd_sbox[i] = sbox_entry(8'(i));
		for (int i = 0; i < 256; i++) inv_sbox[fwd_sbox[i]] = 8'(i);
		key_size_reg = '0;
		key_word_reg = '{default: '0};
		sched_valid = 1'b0;
		sched_rounds = 0;
		last_result = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_key();
		test_standard_keys();
		test_spare_index();
		test_random_blocks(1450);
		repeat (40) @(posedge clk);
		$display("covered %0d blocks (%0d decrypts), %0d register writes, %0d results",
			n_blocks, n_decrypts, n_writes, n_results);
		$display("key sizes 128/192/256 and the saturating size, spare indexes, round trips");
		if (errors == 0 && result_queue.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> aes_block_cipher.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_key_sched.sv
hw/rtl/aes_block_cipher.sv
bench/aes_block_cipher_tb.sv
